// ===== hdl/itdf_pkg.sv =====
`timescale 1ns / 1ps

package itdf_pkg;

   // geometry
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int DD_BITS         = 8;    // magnitude bits converted per pipeline stage
   localparam int POS_W           = 6;    // character position within one text, up to 61
   localparam int CHAR_W          = 8;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 8;

   localparam logic [POS_W-1:0] MAX_WIDTH_CAP = 6'd60;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_OPEN  = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] SEP_RESET  = 8'h2C;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_SIGN_MODE       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_USE_GROUPING    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ZERO_EMPTY      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_WIDTH       = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_GROUP_SEPARATOR = 3'd4;

   // sign modes
   localparam logic [1:0] SIGN_NONE   = 2'd0;
   localparam logic [1:0] SIGN_MINUS  = 2'd1;
   localparam logic [1:0] SIGN_ALWAYS = 2'd2;
   localparam logic [1:0] SIGN_PAREN  = 2'd3;

endpackage

// ===== hdl/int_to_decimal_text_formatter.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  req_tdata: value (signed, zero filled to bytes)
// rsp       out  rsp_tvalid/rsp_tready  rsp_tdata: char_code, rsp_tuser: empty_text,
//                                       rsp_tlast: last_char
// csr       in   csr_we                 csr_addr: register index, csr_wdata: value
//
// one character leaves per cycle while the receiver accepts it; a number's text is
// 1 to 62 characters long, and the single character serializer sets the sustained rate
// magnitude is converted to bcd in 8-bit slices of shift-and-add-3, one slice per stage
// reset is synchronous, clears all valid bits and returns the control registers to defaults
// back pressure ripples stage by stage; a stalled stage holds its contents

module int_to_decimal_text_formatter #(
   parameter int VALUE_WIDTH = itdf_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // req
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    req_tdata,   // [VALUE_WIDTH-1:0] value
   // rsp
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [itdf_pkg::CHAR_W-1:0]         rsp_tdata,   // [7:0] char_code
   output logic                                rsp_tuser,   // [0] empty_text
   output logic                                rsp_tlast,
   // csr
   input  logic                                csr_we,
   input  logic [itdf_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [itdf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import itdf_pkg::*;

   localparam int NS    = (VALUE_WIDTH + DD_BITS - 1) / DD_BITS;  // conversion stages
   localparam int MW    = NS * DD_BITS;                           // padded magnitude width
   localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;     // decimal digits of 2^W-1
   localparam int BCD_W = NDIG * 4;
   localparam int ND_W  = $clog2(NDIG + 1);

   // ---------------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------------
   logic [1:0]        sign_mode_ff;
   logic              use_grouping_ff;
   logic              zero_empty_ff;
   logic [POS_W-1:0]  min_width_ff;
   logic [CHAR_W-1:0] group_separator_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_mode_ff       <= SIGN_MINUS;
         use_grouping_ff    <= 1'b0;
         zero_empty_ff      <= 1'b0;
         min_width_ff       <= '0;
         group_separator_ff <= SEP_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SIGN_MODE:       sign_mode_ff       <= csr_wdata[1:0];
            REG_USE_GROUPING:    use_grouping_ff    <= csr_wdata[0];
            REG_ZERO_EMPTY:      zero_empty_ff      <= csr_wdata[0];
            REG_MIN_WIDTH:       min_width_ff       <= csr_wdata[POS_W-1:0];
            REG_GROUP_SEPARATOR: group_separator_ff <= csr_wdata;
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // pipeline storage: stage 0 holds sign and magnitude, stages 1..NS the bcd slices
   // ---------------------------------------------------------------------------------
   logic              v_ff    [0:NS];
   logic              neg_ff  [0:NS];
   logic              zero_ff [0:NS];
   logic [MW-1:0]     bin_ff  [0:NS-1];
   logic [MW-1:0]     bin_in  [0:NS-1];
   logic [BCD_W-1:0]  bcd_ff  [1:NS];
   logic [BCD_W-1:0]  bcd_in  [1:NS];
   logic              dd_rdy  [0:NS];

   // length stage
   logic              len_v_ff;
   logic              len_neg_ff;
   logic              len_zero_ff;
   logic [BCD_W-1:0]  len_bcd_ff;
   logic [POS_W-1:0]  len_nlen_ff;
   logic [POS_W-1:0]  len_nlen_in;
   logic              len_rdy;

   // serializer
   logic              ser_valid_ff;
   logic              ser_empty_ff;
   logic              ser_has_sign_ff;
   logic [CHAR_W-1:0] ser_sign_char_ff;
   logic [POS_W-1:0]  ser_pad_end_ff;
   logic [POS_W-1:0]  ser_dig_end_ff;
   logic [POS_W-1:0]  ser_last_pos_ff;
   logic [POS_W-1:0]  ser_pos_ff;
   logic [BCD_W-1:0]  ser_bcd_ff;
   logic              ser_has_sign_in;
   logic [CHAR_W-1:0] ser_sign_char_in;
   logic [POS_W-1:0]  ser_pad_end_in;
   logic [POS_W-1:0]  ser_dig_end_in;
   logic [POS_W-1:0]  ser_last_pos_in;
   logic              ser_empty_in;
   logic              ser_rdy;
   logic              ser_done;
   logic              emit;

   // output register
   logic              rsp_tvalid_ff;
   logic [CHAR_W-1:0] rsp_tdata_ff;
   logic              rsp_tuser_ff;
   logic              rsp_tlast_ff;
   logic [CHAR_W-1:0] rsp_tdata_in;
   logic              rsp_tlast_in;
   logic              out_load;

   // ---------------------------------------------------------------------------------
   // back pressure: a stage takes new contents when empty or when its own contents move
   // ---------------------------------------------------------------------------------
   assign out_load = !rsp_tvalid_ff || rsp_tready;
   assign emit     = ser_valid_ff && out_load;
   assign ser_done = emit && (ser_pos_ff == ser_last_pos_ff);
   assign ser_rdy  = !ser_valid_ff || ser_done;
   assign len_rdy  = !len_v_ff || ser_rdy;

   always_comb begin
      dd_rdy[NS] = !v_ff[NS] || len_rdy;
      for (int s = NS - 1; s >= 0; s--) begin
         dd_rdy[s] = !v_ff[s] || dd_rdy[s+1];
      end
   end

   assign req_tready = dd_rdy[0];

   // ---------------------------------------------------------------------------------
   // stage 0: sign and unsigned magnitude (most negative value wraps to 2^(W-1))
   // ---------------------------------------------------------------------------------
   logic [VALUE_WIDTH-1:0] raw;
   logic [VALUE_WIDTH-1:0] mag;
   logic                   neg0_in;
   logic                   zero0_in;

   assign raw      = req_tdata[VALUE_WIDTH-1:0];
   assign neg0_in  = raw[VALUE_WIDTH-1];
   assign zero0_in = (raw == '0);
   assign mag      = neg0_in ? (~raw) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1} : raw;
   assign bin_in[0] = MW'(mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (dd_rdy[0]) begin
         v_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (dd_rdy[0]) begin
         neg_ff[0]  <= neg0_in;
         zero_ff[0] <= zero0_in;
         bin_ff[0]  <= bin_in[0];
      end
   end

   // ---------------------------------------------------------------------------------
   // stages 1..NS: shift-and-add-3, DD_BITS magnitude bits per stage, msb first
   // ---------------------------------------------------------------------------------
   for (genvar s = 1; s <= NS; s++) begin : g_dd
      logic [BCD_W-1:0] bcd_src;
      logic [MW-1:0]    bin_nxt;

      if (s == 1) begin : g_first
         assign bcd_src = '0;
      end else begin : g_rest
         assign bcd_src = bcd_ff[s-1];
      end

      always_comb begin
         logic [BCD_W-1:0] b;
         logic [MW-1:0]    m;
         b = bcd_src;
         m = bin_ff[s-1];
         for (int k = 0; k < DD_BITS; k++) begin
            for (int d = 0; d < NDIG; d++) begin
               if (b[d*4 +: 4] >= 4'd5) begin
                  b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
               end
            end
            b = {b[BCD_W-2:0], m[MW-1]};
            m = {m[MW-2:0], 1'b0};
         end
         bcd_in[s] = b;
         bin_nxt   = m;
      end

      if (s < NS) begin : g_bin
         assign bin_in[s] = bin_nxt;
         always_ff @(posedge clock) begin
            if (dd_rdy[s]) begin
               bin_ff[s] <= bin_in[s];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (dd_rdy[s]) begin
            v_ff[s] <= v_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (dd_rdy[s]) begin
            neg_ff[s]  <= neg_ff[s-1];
            zero_ff[s] <= zero_ff[s-1];
            bcd_ff[s]  <= bcd_in[s];
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // length stage: digit count and count of digits plus separators
   // ---------------------------------------------------------------------------------
   always_comb begin
      logic [ND_W-1:0]  nd;
      logic [POS_W-1:0] seps;
      nd   = ND_W'(1);
      seps = '0;
      for (int i = 1; i < NDIG; i++) begin
         if (bcd_ff[NS][i*4 +: 4] != 4'd0) begin
            nd = ND_W'(i + 1);
         end
      end
      // one separator for every full group of three below the leading group
      for (int k = 1; 3 * k < NDIG; k++) begin
         if (nd > ND_W'(3 * k)) begin
            seps = seps + POS_W'(1);
         end
      end
      len_nlen_in = POS_W'(nd) + (use_grouping_ff ? seps : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_v_ff <= 1'b0;
      end else if (len_rdy) begin
         len_v_ff <= v_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (len_rdy) begin
         len_neg_ff  <= neg_ff[NS];
         len_zero_ff <= zero_ff[NS];
         len_bcd_ff  <= bcd_ff[NS];
         len_nlen_ff <= len_nlen_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // serializer load: text layout is sign | zero padding | digits | closing paren
   // ---------------------------------------------------------------------------------
   always_comb begin
      logic [POS_W-1:0] width;
      logic [POS_W-1:0] pad;
      logic             has_close;
      width = (min_width_ff > MAX_WIDTH_CAP) ? MAX_WIDTH_CAP : min_width_ff;
      pad   = (width > len_nlen_ff) ? width - len_nlen_ff : '0;
      ser_has_sign_in = (sign_mode_ff == SIGN_ALWAYS)
                     || (len_neg_ff && (sign_mode_ff == SIGN_MINUS
                                     || sign_mode_ff == SIGN_PAREN));
      has_close = len_neg_ff && (sign_mode_ff == SIGN_PAREN);
      if (!len_neg_ff) begin
         ser_sign_char_in = CHAR_PLUS;
      end else if (sign_mode_ff == SIGN_PAREN) begin
         ser_sign_char_in = CHAR_OPEN;
      end else begin
         ser_sign_char_in = CHAR_MINUS;
      end
      ser_empty_in    = zero_empty_ff && len_zero_ff;
      ser_pad_end_in  = POS_W'(ser_has_sign_in) + pad;
      ser_dig_end_in  = ser_pad_end_in + len_nlen_ff;
      ser_last_pos_in = ser_empty_in ? '0
                                     : ser_dig_end_in + POS_W'(has_close) - POS_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_pos_ff   <= '0;
      end else if (ser_rdy) begin
         ser_valid_ff <= len_v_ff;
         ser_pos_ff   <= '0;
      end else if (emit) begin
         ser_pos_ff   <= ser_pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ser_rdy) begin
         ser_empty_ff     <= ser_empty_in;
         ser_has_sign_ff  <= ser_has_sign_in;
         ser_sign_char_ff <= ser_sign_char_in;
         ser_pad_end_ff   <= ser_pad_end_in;
         ser_dig_end_ff   <= ser_dig_end_in;
         ser_last_pos_ff  <= ser_last_pos_in;
         ser_bcd_ff       <= len_bcd_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // character at the current position
   // ---------------------------------------------------------------------------------
   always_comb begin
      logic [POS_W-1:0] r;    // place counted from the least significant end of the digits
      logic [POS_W-1:0] di;   // digit index after removing separators
      logic [3:0]       dig;
      r   = ser_dig_end_ff - POS_W'(1) - ser_pos_ff;
      di  = use_grouping_ff ? r - (r >> 2) : r;
      dig = 4'd0;
      for (int i = 0; i < NDIG; i++) begin
         if (di == POS_W'(i)) begin
            dig = ser_bcd_ff[i*4 +: 4];
         end
      end
      if (ser_empty_ff) begin
         rsp_tdata_in = CHAR_NUL;
      end else if (ser_has_sign_ff && ser_pos_ff == '0) begin
         rsp_tdata_in = ser_sign_char_ff;
      end else if (ser_pos_ff < ser_pad_end_ff) begin
         rsp_tdata_in = CHAR_ZERO;
      end else if (ser_pos_ff < ser_dig_end_ff) begin
         // every fourth place from the right is a separator
         if (use_grouping_ff && r[1:0] == 2'd3) begin
            rsp_tdata_in = group_separator_ff;
         end else begin
            rsp_tdata_in = CHAR_ZERO + CHAR_W'(dig);
         end
      end else begin
         rsp_tdata_in = CHAR_CLOSE;
      end
      rsp_tlast_in = (ser_pos_ff == ser_last_pos_ff);
   end

   // ---------------------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= ser_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= ser_empty_ff;
         rsp_tlast_ff <= rsp_tlast_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

// ===== hdl/itdf_checker.sv =====
`timescale 1ns / 1ps

module itdf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [itdf_pkg::CHAR_W-1:0] rsp_tdata,
   input logic                        rsp_tuser,
   input logic                        rsp_tlast
);
   import itdf_pkg::*;

   // empty text is a single transaction with a null character
   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == CHAR_NUL)
      else $error("empty text result is not a lone null transaction");

   // a character inside a text never claims the text is empty
   a_no_empty_mid: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(rsp_tvalid && rsp_tready && !rsp_tlast) && rsp_tvalid
      |-> !rsp_tuser)
      else $error("empty flag inside a running text");

   // nothing leaves in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // the input side is ready in the cycle after reset, the pipe is empty then
   a_req_ready_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

endmodule

bind int_to_decimal_text_formatter itdf_checker u_itdf_checker (.*);

// ===== tb/int_to_decimal_text_formatter_test.sv =====
`timescale 1ns / 1ps

module int_to_decimal_text_formatter_test;
   import itdf_pkg::*;

   localparam int VALUE_WIDTH  = 32;
   localparam int TDATA_W      = ((VALUE_WIDTH + 7) / 8) * 8;
   // req transaction to first rsp transaction, plus some margin
   localparam int SETTLE       = (VALUE_WIDTH + 7) / 8 + 4 + 4;
   // slowest legal run is well under this: ~200 numbers x 62 chars, with receiver stalls
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_PHASES    = 6;
   localparam int ITEMS_PER_PHASE  = 25;

   // indexes past the register file, writes there must do nothing
   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED_LO = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              empty_text;
      logic              last_char;
   } text_char_t;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   // block ports, all known from time zero
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata  = '0;   // [31:0] value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [CHAR_W-1:0]     rsp_tdata;         // [7:0] char_code
   logic                  rsp_tuser;         // [0] empty_text
   logic                  rsp_tlast;         // last_char
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int_to_decimal_text_formatter #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // shadow copy of the control registers, reset values
   logic [1:0]        sign_mode_cfg  = SIGN_MINUS;
   logic              grouping_cfg   = 1'b0;
   logic              zero_empty_cfg = 1'b0;
   logic [POS_W-1:0]  min_width_cfg  = '0;
   logic [CHAR_W-1:0] separator_cfg  = SEP_RESET;

   // numbers waiting to be sent, and characters the block still owes us
   logic [VALUE_WIDTH-1:0] pending_values[$];
   text_char_t             expected_chars[$];

   int  numbers_queued   = 0;
   int  numbers_accepted = 0;
   int  chars_checked    = 0;
   int  settings_applied = 0;
   int  mismatches       = 0;
   int  cycle_count      = 0;
   bit  quiet            = 1'b0;   // no idling on either side once set
   bit  req_fire         = 1'b0;   // req transaction at the last rising edge
   int  send_gap         = 0;
   int  stall_left       = 0;

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   // expected text of one number under the current register settings
   function automatic void format_decimal(input logic [VALUE_WIDTH-1:0] value);
      logic                   neg;
      logic [VALUE_WIDTH-1:0] mag;
      logic [CHAR_W-1:0]      digits_rev[$];
      logic [CHAR_W-1:0]      text[$];
      int                     group_count;
      int                     width;
      int                     pad;
      text_char_t             entry;
      neg = value[VALUE_WIDTH-1];
      // unsigned magnitude, the most negative value maps onto itself
      mag = neg ? (~value + 1'b1) : value;
      group_count = 0;
      if (zero_empty_cfg && value == '0) begin
         entry = '{char_code: CHAR_NUL, empty_text: 1'b1, last_char: 1'b1};
         expected_chars.push_back(entry);
         return;
      end
      // digits least significant first, separator after every third digit when grouping is on
      do begin
         digits_rev.push_back(CHAR_ZERO + CHAR_W'(mag % 10));
         if (grouping_cfg)
            group_count++;
         mag = mag / 10;
         if (mag != 0 && group_count > 2) begin
            group_count = 0;
            digits_rev.push_back(separator_cfg);
         end
      end while (mag != 0);
      width = (min_width_cfg > MAX_WIDTH_CAP) ? int'(MAX_WIDTH_CAP) : int'(min_width_cfg);
      pad   = (digits_rev.size() < width) ? width - digits_rev.size() : 0;
      if (sign_mode_cfg == SIGN_ALWAYS)
         text.push_back(neg ? CHAR_MINUS : CHAR_PLUS);
      else if (neg && sign_mode_cfg == SIGN_MINUS)
         text.push_back(CHAR_MINUS);
      else if (neg && sign_mode_cfg == SIGN_PAREN)
         text.push_back(CHAR_OPEN);
      repeat (pad) text.push_back(CHAR_ZERO);
      while (digits_rev.size() > 0)
         text.push_back(digits_rev.pop_back());
      if (neg && sign_mode_cfg == SIGN_PAREN)
         text.push_back(CHAR_CLOSE);
      foreach (text[k]) begin
         entry = '{char_code: text[k], empty_text: 1'b0, last_char: (k == text.size() - 1)};
         expected_chars.push_back(entry);
      end
   endfunction

   // monitor: predict on every req transaction, check every rsp transaction
   always @(posedge clock) begin
      text_char_t want;
      req_fire <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         cycle_count++;
         if (req_tvalid && req_tready) begin
            format_decimal(req_tdata[VALUE_WIDTH-1:0]);
            numbers_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("character %02h with nothing expected", rsp_tdata));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== want.char_code)
                  report_mismatch($sformatf("char_code %02h, expected %02h",
                                            rsp_tdata, want.char_code));
               if (rsp_tuser !== want.empty_text)
                  report_mismatch($sformatf("empty_text %b, expected %b",
                                            rsp_tuser, want.empty_text));
               if (rsp_tlast !== want.last_char)
                  report_mismatch($sformatf("last_char %b, expected %b",
                                            rsp_tlast, want.last_char));
               chars_checked++;
            end
         end
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, expected_chars.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // sender: next number once the slot is free, random gaps between numbers until quiet
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_values.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= TDATA_W'(pending_values.pop_front());
            if (!quiet && $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: back pressure in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 14);
      end
   end

   // one register write, then the enable is dropped again; called at a falling edge
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_SIGN_MODE:       sign_mode_cfg  = data[1:0];
         REG_USE_GROUPING:    grouping_cfg   = data[0];
         REG_ZERO_EMPTY:      zero_empty_cfg = data[0];
         REG_MIN_WIDTH:       min_width_cfg  = data[POS_W-1:0];
         REG_GROUP_SEPARATOR: separator_cfg  = data;
         default: ;   // unused index, ignored by the block too
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] sign_mode,
                                 input logic [CSR_DATA_W-1:0] grouping,
                                 input logic [CSR_DATA_W-1:0] zero_empty,
                                 input logic [CSR_DATA_W-1:0] min_width,
                                 input logic [CSR_DATA_W-1:0] separator);
      csr_write(REG_SIGN_MODE, sign_mode);
      csr_write(REG_USE_GROUPING, grouping);
      csr_write(REG_ZERO_EMPTY, zero_empty);
      csr_write(REG_MIN_WIDTH, min_width);
      csr_write(REG_GROUP_SEPARATOR, separator);
      settings_applied++;
   endtask

   task automatic send_number(input logic [VALUE_WIDTH-1:0] value);
      pending_values.push_back(value);
      numbers_queued++;
   endtask

   // every number has produced its text; every number yields at least one character,
   // so an empty expectation queue means the pipeline is drained too
   task automatic wait_idle();
      while (numbers_accepted != numbers_queued || expected_chars.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // mix of full-range values, small values, powers of ten and edges
   function automatic logic [VALUE_WIDTH-1:0] random_value();
      int p;
      p = 1;
      case ($urandom_range(0, 5))
         0: return VALUE_WIDTH'($urandom_range(0, 2000)) - VALUE_WIDTH'(1000);
         1: begin
            repeat ($urandom_range(0, 9)) p *= 10;
            p = p + $urandom_range(0, 2) - 1;
            return $urandom_range(0, 1) ? VALUE_WIDTH'(-p) : VALUE_WIDTH'(p);
         end
         2: case ($urandom_range(0, 5))
            0: return '0;
            1: return VALUE_WIDTH'(1);
            2: return '1;
            3: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            4: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            default: return {1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1};
         endcase
         default: return VALUE_WIDTH'($urandom);
      endcase
   endfunction

   initial begin
      logic [POS_W-1:0] width_pick;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: minus only, no grouping, no padding
      send_number('0);
      send_number(32'sd1);
      send_number(-32'sd1);
      send_number(32'h7fff_ffff);
      send_number(32'h8000_0000);
      send_number(32'sd9);
      send_number(32'sd10);
      send_number(-32'sd999);
      wait_idle();

      // no sign, grouping with '_', empty zero
      apply_settings({6'b0, SIGN_NONE}, 8'd1, 8'd1, 8'd0, 8'h5f);
      send_number('0);
      send_number(-32'sd1234567);
      send_number(32'h7fff_ffff);
      send_number(32'h8000_0000);
      send_number(32'sd999);
      send_number(32'sd1000);
      wait_idle();

      // sign always, width 63 is capped at 60, nul separator with grouping off
      apply_settings({6'b0, SIGN_ALWAYS}, 8'd0, 8'd0, 8'hff, 8'h00);
      send_number('0);
      send_number(-32'sd5);
      send_number(32'sd12345);
      wait_idle();

      // parentheses with upper data bits set, odd width, all-ones separator
      apply_settings({6'b111111, SIGN_PAREN}, 8'hff, 8'hff, 8'd7, 8'hff);
      // writes past the last register must change nothing
      csr_write(REG_UNUSED_LO, 8'h00);
      csr_write(REG_UNUSED_HI, 8'h02);
      send_number(-32'sd1);
      send_number(32'sd1);
      send_number('0);
      send_number(32'h8000_0000);
      send_number(-32'sd1000);
      send_number(32'sd123456);
      wait_idle();

      // random settings per phase, mostly short widths, now and then near the cap
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         width_pick = ($urandom_range(0, 5) == 0) ? POS_W'($urandom_range(55, 63))
                                                  : POS_W'($urandom_range(0, 14));
         apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                        {2'($urandom), width_pick}, 8'($urandom));
         if ($urandom_range(0, 2) == 0)
            csr_write(CSR_ADDR_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                      8'($urandom));
         if (phase == RANDOM_PHASES - 1)
            quiet = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // sender holds off until the block has emptied out
            if (n == ITEMS_PER_PHASE / 2 && (phase == 0 || $urandom_range(0, 1) == 1))
               wait_idle();
            send_number(random_value());
         end
         wait_idle();
      end

      $display("covered %0d numbers under %0d register settings, %0d characters checked",
               numbers_accepted, settings_applied, chars_checked);
      $display("sign modes, grouping, empty zero, padding up to the width cap, extreme values");
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/itdf_pkg.sv
hdl/int_to_decimal_text_formatter.sv
hdl/itdf_checker.sv
tb/int_to_decimal_text_formatter_test.sv
